@@ rtl/core/mcd_pkg.sv @@
// Package with shared types and constants for the MDA/CGA display decoder.
package mcd_pkg;

  localparam int MemBytesDefault = 16384;

  localparam logic [1:0] KIND_PORT  = 2'd0;
  localparam logic [1:0] KIND_MEM   = 2'd1;
  localparam logic [1:0] KIND_TEXT  = 2'd2;
  localparam logic [1:0] KIND_GRAPH = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [1:0] ADAPTER_MDA = 2'd0;

  localparam logic [15:0] MONO_BASE  = 16'h03b0;
  localparam logic [15:0] COLOR_BASE = 16'h03d0;

  localparam logic [4:0] CRTC_COLS     = 5'd1;
  localparam logic [4:0] CRTC_START_HI = 5'd12;
  localparam logic [4:0] CRTC_START_LO = 5'd13;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] port;
    logic [7:0]  value;
    logic [13:0] mem_address;
    logic [10:0] cell_index;
    logic        blink_phase;
    logic [7:0]  scan_row;
    logic [6:0]  byte_column;
  } item_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic [3:0] fore_index;
    logic [3:0] back_index;
    logic       underline;
    logic [1:0] status;
    logic       last;
  } result_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;   // register the input word and do writes
    logic fetch;  // read memory for a loaded fetch item
    logic shift;  // advance to next pixel
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_write;  // loaded item has no result
    logic early;     // result known without memory read
    logic [3:0] npix;  // results minus one for a fetch item
  } stat_t;

endpackage

@@ rtl/core/mcd_ctrl.sv @@
// Controller state machine sequencing load, fetch and result delivery.
module mcd_ctrl
  import mcd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  output logic  out_tvalid,
  input  logic  out_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_READ, S_OUT} state_t;

  state_t     state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat.is_write) begin
          state_nxt = S_IDLE;
        end else if (stat.early) begin
          cnt_nxt   = '0;
          state_nxt = S_OUT;
        end else begin
          cmd.fetch = 1'b1;
          cnt_nxt   = stat.npix;
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_OUT;
      S_OUT: begin
        if (out_tready) begin
          if (cnt_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.shift = 1'b1;
            cnt_nxt   = cnt_r - 4'd1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

@@ rtl/core/mcd_datapath.sv @@
// Datapath with register file, video memory and cell and pixel decode.
module mcd_datapath
  import mcd_pkg::*;
#(
  parameter int MEM_BYTES = MemBytesDefault
)(
  input  logic       clk,
  input  logic       rst_n,
  input  item_t      item,
  input  logic [1:0] adapter_type,
  input  cmd_t       cmd,
  output stat_t      stat,
  output result_t    res
);

  localparam int AW = $clog2(MEM_BYTES);

  logic [7:0]  mem [MEM_BYTES];
  item_t       it_r;
  logic [4:0]  crtc_select_r;
  logic [7:0]  cols_r;
  logic [13:0] start_r;
  logic [7:0]  mode_r;
  logic [7:0]  csel_r;
  logic [7:0]  rd_r;
  logic        rd_sel_r;
  logic [7:0]  chr_r;
  logic [7:0]  pix_r;
  logic [3:0]  left_r;
  result_t     early_r;
  logic        early_sel_r;
  logic        text_r;

  logic        mono, graphics, bad, wide;
  logic [15:0] base;
  logic [12:0] cell_count;
  logic [13:0] taddr, gaddr, faddr;
  logic [13:0] row;
  result_t     er;
  logic [3:0]  colors [4];
  logic [3:0]  inten;
  logic [7:0]  attr;
  logic [1:0]  psel;

  assign mono     = (adapter_type == ADAPTER_MDA);
  assign base     = mono ? MONO_BASE : COLOR_BASE;
  assign graphics = !mono && mode_r[1];
  assign wide     = mode_r[4];
  assign bad      = graphics ? (cols_r != 8'd40)
                  : (cols_r != 8'd80 && (mono || cols_r != 8'd40));
  assign cell_count = 13'(cols_r) * 13'd25;

  assign taddr = 14'((14'(start_r + 14'(it_r.cell_index)) << 1))
               & (mono ? 14'h0fff : 14'h3fff);
  assign row   = 14'((start_r << 1) + 14'(it_r.scan_row[7:1]) * 7'd80);
  assign gaddr = (14'(row + 14'(it_r.byte_column)) & 14'h1fff)
               | {it_r.scan_row[0], 13'd0};

  always_comb begin
    er = '0;
    if (bad || ((it_r.kind == KIND_TEXT) == graphics)) begin
      er.status = ST_BAD;
    end else if (it_r.kind == KIND_TEXT) begin
      if ({2'b0, it_r.cell_index} >= cell_count) er.status = ST_RANGE;
      else if (!mode_r[3]) er.char_code = 8'd32;
    end else if (it_r.scan_row >= 8'd200 || it_r.byte_column >= 7'd80) begin
      er.status = ST_RANGE;
    end
  end

  assign stat.is_write = (it_r.kind == KIND_PORT) || (it_r.kind == KIND_MEM);
  assign stat.early    = (it_r.kind == KIND_TEXT) ? (er.status != ST_OK || !mode_r[3])
                                                : (er.status != ST_OK);
  assign stat.npix     = (it_r.kind == KIND_TEXT) ? 4'd0 : (wide ? 4'd7 : 4'd3);
  assign faddr         = (it_r.kind == KIND_TEXT) ? (taddr | 14'd1) : gaddr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crtc_select_r <= '0;
      cols_r        <= 8'd80;
      start_r       <= '0;
      mode_r        <= '0;
      csel_r        <= '0;
    end else if (cmd.load && item.kind == KIND_PORT) begin
      if (item.port >= base && item.port <= base + 16'd7) begin
        if (!item.port[0]) crtc_select_r <= item.value[4:0];
        else if (crtc_select_r == CRTC_COLS) cols_r <= item.value;
        else if (crtc_select_r == CRTC_START_HI) start_r[13:8] <= item.value[5:0];
        else if (crtc_select_r == CRTC_START_LO) start_r[7:0] <= item.value;
      end else if (item.port == base + 16'd8) begin
        mode_r <= item.value;
      end else if (!mono && item.port == base + 16'd9) begin
        csel_r <= item.value;
      end
    end
  end

  // Single-port memory: write on load, fetch read, then character read.
  always_ff @(posedge clk) begin
    if (cmd.load && item.kind == KIND_MEM) mem[AW'(item.mem_address)] <= item.value;
    if (cmd.fetch) rd_r <= mem[AW'(faddr)];
    else if (rd_sel_r) chr_r <= mem[AW'(taddr)];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) it_r <= item;
    if (cmd.fetch) begin
      rd_sel_r <= 1'b1;
      left_r   <= stat.npix;
    end else begin
      rd_sel_r <= 1'b0;
    end
    if (rd_sel_r) pix_r <= rd_r;
    else if (cmd.shift) pix_r <= wide ? {pix_r[6:0], 1'b0} : {pix_r[5:0], 2'b0};
    if (cmd.shift) left_r <= left_r - 4'd1;
    if (stat.early && !stat.is_write) begin
      early_r <= er;
      left_r  <= '0;
    end
    early_sel_r <= cmd.load ? 1'b0 : (early_sel_r | (stat.early && !stat.is_write));
    text_r <= (it_r.kind == KIND_TEXT);
  end

  assign inten = csel_r[4] ? 4'd8 : 4'd0;
  always_comb begin
    colors[0] = csel_r[3:0];
    colors[1] = inten + (mode_r[2] ? 4'd3 : (csel_r[5] ? 4'd3 : 4'd2));
    colors[2] = inten + (mode_r[2] ? 4'd4 : (csel_r[5] ? 4'd5 : 4'd4));
    colors[3] = inten + (mode_r[2] ? 4'd7 : (csel_r[5] ? 4'd7 : 4'd6));
    psel = pix_r[7:6];
  end

  assign attr = pix_r;

  always_comb begin
    res = '0;
    if (early_sel_r) begin
      res = early_r;
      if (!text_r && early_r.status == ST_OK) begin
        res.last = (left_r == '0);
      end
    end else if (text_r) begin
      res.char_code = chr_r;
      if (mono) begin
        res.fore_index = attr[3] ? 4'd15 : 4'd7;
        case (attr[6:0])
          7'h70: begin res.fore_index = 4'd0; res.back_index = 4'd15; end
          7'h78: begin res.fore_index = 4'd7; res.back_index = 4'd15; end
          7'h00, 7'h08: res.fore_index = 4'd0;
          default: ;
        endcase
        res.underline = (attr[2:0] == 3'd1);
      end else begin
        res.fore_index = attr[3:0];
        res.back_index = attr[7:4] & (mode_r[5] ? 4'd7 : 4'd15);
      end
      if (mode_r[5] && attr[7] && !it_r.blink_phase) res.fore_index = res.back_index;
    end else begin
      if (!mode_r[3]) res.fore_index = '0;
      else if (wide) res.fore_index = pix_r[7] ? csel_r[3:0] : 4'd0;
      else res.fore_index = colors[psel];
      res.last = (left_r == '0);
    end
  end

endmodule

@@ rtl/core/mda_cga_display_decoder_core.sv @@
// Top level of the MDA/CGA display decoder.
// Items arrive on the in_ stream: port writes, video memory writes, text cell
// fetches and graphics byte fetches, with the item kind on in_tuser. Results
// leave on the out_ stream, one word per text cell or error, and four or eight
// pixel words per graphics byte with out_tlast on the final pixel. The adapter
// type must be written through the cfg_ channel only while the block is idle;
// the block itself does not enforce this. One item is handled at a time. An
// error or a disabled-display text cell has its word decided and registered in
// the evaluate state, with no memory read. A fetched cell or byte passes through
// the evaluate and read states before its first word is offered, because the
// video memory is read and registered first. A disabled graphics byte still
// takes the memory read. Pixels follow one per cycle while the receiver accepts
// them. The next item can be taken in the cycle after the last word leaves.
// When the receiver stalls, the current word holds and no item is accepted.
// Reset returns the registers to 80 columns, CGA, mode zero; video memory is
// not cleared and must be written before it is read.
module mda_cga_display_decoder_core
  import mcd_pkg::*;
#(
  parameter int MEM_BYTES = MemBytesDefault
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,  // port, value, mem_address, cell_index,
                                 // blink_phase, scan_row, byte_column, zeros
  input  logic [1:0]  in_tuser,  // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata, // char_code, fore_index, back_index,
                                 // underline, status, zeros
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data
);

  item_t      item;
  result_t    res;
  cmd_t       cmd;
  stat_t      stat;
  logic [1:0] adapter_r;

  assign item.kind        = in_tuser;
  assign item.port        = in_tdata[15:0];
  assign item.value       = in_tdata[23:16];
  assign item.mem_address = in_tdata[37:24];
  assign item.cell_index  = in_tdata[48:38];
  assign item.blink_phase = in_tdata[49];
  assign item.scan_row    = in_tdata[57:50];
  assign item.byte_column = in_tdata[64:58];

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) adapter_r <= 2'd1;
    else if (cfg_valid) adapter_r <= cfg_data;
  end

  mcd_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
    .stat(stat), .cmd(cmd)
  );

  mcd_datapath #(.MEM_BYTES(MEM_BYTES)) u_dp (
    .clk, .rst_n, .item(item), .adapter_type(adapter_r), .cmd(cmd),
    .stat(stat), .res(res)
  );

  assign out_tdata = {5'd0, res.status, res.underline, res.back_index,
                      res.fore_index, res.char_code};
  assign out_tlast = res.last;

endmodule

@@ rtl/core/mcd_checker.sv @@
// Port-level checker for the display decoder, bound to the top level.
module mcd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input taken while word pending");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled word changed");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[18:17] != 2'd0 |-> !out_tlast)
    else $error("error word marked last");

  a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("back to back accept");

endmodule

bind mda_cga_display_decoder_core mcd_checker u_chk (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
  .out_tdata, .out_tlast
);

@@ sim/tb.sv @@
// Self-checking testbench for the MDA/CGA display decoder core.
module tb;
  import mcd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] char_code;
    logic [3:0] fore_index;
    logic [3:0] back_index;
    logic       underline;
    logic [1:0] status;
    logic       last;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_data = '0;

  mda_cga_display_decoder_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #2ns clk = ~clk;

  logic [7:0]  vram [16384];
  logic        vram_ok [16384];
  logic [4:0]  m_crtc_sel;
  logic [7:0]  m_cols;
  logic [13:0] m_start;
  logic [7:0]  m_mode;
  logic [7:0]  m_csel;
  logic [1:0]  m_adapter;

  item_t  pending_items [$];
  pixel_t expected_words [$];
  int     errors = 0;
  int     words_seen = 0;
  int     items_sent = 0;
  bit     quiet_in = 1'b0;
  bit     quiet_out = 1'b0;
  bit     in_taken = 1'b0;

  function automatic logic [71:0] pack_item(item_t it);
    return {7'd0, it.byte_column, it.scan_row, it.blink_phase, it.cell_index,
            it.mem_address, it.value, it.port};
  endfunction

  function automatic pixel_t mk(logic [7:0] ch, logic [3:0] fg, logic [3:0] bg,
                                logic ul, logic [1:0] st, logic lst);
    pixel_t p;
    p.char_code = ch; p.fore_index = fg; p.back_index = bg;
    p.underline = ul; p.status = st; p.last = lst;
    return p;
  endfunction

  task automatic apply_port(logic [15:0] port, logic [7:0] v);
    logic        mono;
    logic [15:0] base;
    mono = (m_adapter == ADAPTER_MDA);
    base = mono ? MONO_BASE : COLOR_BASE;
    if (port >= base && port <= base + 16'd7) begin
      if (!port[0]) m_crtc_sel = v[4:0];
      else if (m_crtc_sel == CRTC_COLS) m_cols = v;
      else if (m_crtc_sel == CRTC_START_HI) m_start = {v[5:0], m_start[7:0]};
      else if (m_crtc_sel == CRTC_START_LO) m_start = {m_start[13:8], v};
    end else if (port == base + 16'd8) begin
      m_mode = v;
    end else if (!mono && port == base + 16'd9) begin
      m_csel = v;
    end
  endtask

  task automatic predict_text(item_t it);
    logic        mono;
    logic [13:0] addr;
    logic [7:0]  attr;
    logic [3:0]  fg, bg;
    logic        ul, blink;
    mono = (m_adapter == ADAPTER_MDA);
    blink = m_mode[5];
    ul = 1'b0;
    if (32'(it.cell_index) >= 32'(m_cols) * 25) begin
      expected_words.push_back(mk('0, '0, '0, 1'b0, ST_RANGE, 1'b0));
      return;
    end
    if (!m_mode[3]) begin
      expected_words.push_back(mk(8'd32, '0, '0, 1'b0, ST_OK, 1'b0));
      return;
    end
    addr = 14'((32'(m_start) + 32'(it.cell_index)) * 2) & (mono ? 14'h0fff : 14'h3fff);
    attr = vram[addr + 14'd1];
    if (mono) begin
      fg = attr[3] ? 4'd15 : 4'd7;
      bg = 4'd0;
      case (attr[6:0])
        7'h70: begin fg = 4'd0; bg = 4'd15; end
        7'h78: begin fg = 4'd7; bg = 4'd15; end
        7'h00, 7'h08: fg = 4'd0;
        default: ;
      endcase
      ul = (attr[2:0] == 3'd1);
    end else begin
      fg = attr[3:0];
      bg = attr[7:4] & (blink ? 4'd7 : 4'd15);
    end
    if (blink && attr[7] && !it.blink_phase) fg = bg;
    expected_words.push_back(mk(vram[addr], fg, bg, ul, ST_OK, 1'b0));
  endtask

  function automatic logic [13:0] graph_addr(logic [7:0] y, logic [6:0] bx);
    int row;
    row = int'(m_start) * 2 + int'(y / 2) * 80;
    return 14'(((row + int'(bx)) & 16'h1fff) + (y[0] ? 16'h2000 : 0));
  endfunction

  task automatic decode_graphics(item_t it);
    logic       wide;
    logic [3:0] colors [4];
    logic [3:0] in4, c;
    logic [7:0] v;
    int         n;
    wide = m_mode[4];
    if (it.scan_row >= 8'd200 || it.byte_column >= 7'd80) begin
      expected_words.push_back(mk('0, '0, '0, 1'b0, ST_RANGE, 1'b0));
      return;
    end
    n = wide ? 8 : 4;
    if (!m_mode[3]) begin
      for (int k = 0; k < n; k++)
        expected_words.push_back(mk('0, '0, '0, 1'b0, ST_OK, k == n - 1));
      return;
    end
    in4 = m_csel[4] ? 4'd8 : 4'd0;
    colors[0] = wide ? 4'd0 : m_csel[3:0];
    if (wide) begin
      colors[1] = m_csel[3:0]; colors[2] = 4'd0; colors[3] = 4'd0;
    end else if (m_mode[2]) begin
      colors[1] = in4 + 4'd3; colors[2] = in4 + 4'd4; colors[3] = in4 + 4'd7;
    end else if (m_csel[5]) begin
      colors[1] = in4 + 4'd3; colors[2] = in4 + 4'd5; colors[3] = in4 + 4'd7;
    end else begin
      colors[1] = in4 + 4'd2; colors[2] = in4 + 4'd4; colors[3] = in4 + 4'd6;
    end
    v = vram[graph_addr(it.scan_row, it.byte_column)];
    for (int k = 0; k < n; k++) begin
      c = wide ? colors[{1'b0, v[7 - k]}] : colors[(v >> (6 - 2 * k)) & 3];
      expected_words.push_back(mk('0, c, '0, 1'b0, ST_OK, k == n - 1));
    end
  endtask

  task automatic predict_item(item_t it);
    logic graphics, bad;
    case (it.kind)
      KIND_PORT: apply_port(it.port, it.value);
      KIND_MEM: vram[it.mem_address] = it.value;
      default: begin
        graphics = (m_adapter != ADAPTER_MDA) && m_mode[1];
        if (graphics) bad = (m_cols != 8'd40);
        else bad = (m_cols != 8'd80) && ((m_adapter == ADAPTER_MDA) || m_cols != 8'd40);
        if (bad || ((it.kind == KIND_TEXT) == graphics))
          expected_words.push_back(mk('0, '0, '0, 1'b0, ST_BAD, 1'b0));
        else if (it.kind == KIND_TEXT) predict_text(it);
        else decode_graphics(it);
      end
    endcase
  endtask

  // Staging model used only while generating stimulus, so fetches never hit unwritten memory.
  logic [7:0] g_cols, g_mode;
  logic [13:0] g_start;
  logic [4:0] g_sel;
  logic [1:0] g_adapter;

  task automatic gen_port(logic [15:0] port, logic [7:0] v);
    item_t it;
    logic [15:0] base;
    it = '0;
    it.kind = KIND_PORT; it.port = port; it.value = v;
    pending_items.push_back(it);
    base = (g_adapter == ADAPTER_MDA) ? MONO_BASE : COLOR_BASE;
    if (port >= base && port <= base + 16'd7) begin
      if (!port[0]) g_sel = v[4:0];
      else if (g_sel == CRTC_COLS) g_cols = v;
      else if (g_sel == CRTC_START_HI) g_start = {v[5:0], g_start[7:0]};
      else if (g_sel == CRTC_START_LO) g_start = {g_start[13:8], v};
    end else if (port == base + 16'd8) begin
      g_mode = v;
    end
  endtask

  task automatic gen_crtc(logic [4:0] r, logic [7:0] v);
    logic [15:0] base;
    base = (g_adapter == ADAPTER_MDA) ? MONO_BASE : COLOR_BASE;
    gen_port(base + 16'(2 * $urandom_range(0, 3)), {3'($urandom_range(0, 7)), r});
    gen_port(base + 16'(2 * $urandom_range(0, 3) + 1), v);
  endtask

  task automatic gen_mem(logic [13:0] a, logic [7:0] v);
    item_t it;
    it = '0;
    it.kind = KIND_MEM; it.mem_address = a; it.value = v;
    it.port = 16'($urandom); it.cell_index = 11'($urandom);
    pending_items.push_back(it);
    vram_ok[a] = 1'b1;
  endtask

  task automatic gen_text(logic [10:0] idx);
    item_t it;
    logic [13:0] a;
    it = item_t'(67'({$urandom, $urandom, $urandom}));
    it.kind = KIND_TEXT; it.cell_index = idx;
    a = 14'((32'(g_start) + 32'(idx)) * 2) &
        ((g_adapter == ADAPTER_MDA) ? 14'h0fff : 14'h3fff);
    if (!vram_ok[a]) gen_mem(a, 8'($urandom));
    if (!vram_ok[a + 14'd1]) gen_mem(a + 14'd1, 8'($urandom));
    pending_items.push_back(it);
  endtask

  task automatic gen_graph(logic [7:0] y, logic [6:0] bx);
    item_t it;
    logic [13:0] a;
    int row;
    it = item_t'(67'({$urandom, $urandom, $urandom}));
    it.kind = KIND_GRAPH; it.scan_row = y; it.byte_column = bx;
    row = int'(g_start) * 2 + int'(y / 2) * 80;
    a = 14'(((row + int'(bx)) & 16'h1fff) + (y[0] ? 16'h2000 : 0));
    if (y < 200 && bx < 80 && !vram_ok[a]) gen_mem(a, 8'($urandom));
    pending_items.push_back(it);
  endtask

  always @(negedge clk) begin
    item_t nx;
    if (rst_n) begin
      out_tready <= quiet_out ? 1'b1 : ($urandom_range(0, 99) >= 7);
      if (!in_tvalid || in_taken) begin
        if (pending_items.size() > 0 && (quiet_in || $urandom_range(0, 99) >= 7)) begin
          nx = pending_items.pop_front();
          in_tdata  <= pack_item(nx);
          in_tuser  <= nx.kind;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // in_tready is sampled at the edge, so a word taken here has been accepted.
  always @(posedge clk) begin
    item_t  got_item;
    pixel_t got, want;
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      got_item = '0;
      got_item.kind = in_tuser;              got_item.port = in_tdata[15:0];
      got_item.value = in_tdata[23:16];      got_item.mem_address = in_tdata[37:24];
      got_item.cell_index = in_tdata[48:38]; got_item.blink_phase = in_tdata[49];
      got_item.scan_row = in_tdata[57:50];   got_item.byte_column = in_tdata[64:58];
      predict_item(got_item);
      items_sent++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = mk(out_tdata[7:0], out_tdata[11:8], out_tdata[15:12], out_tdata[16],
               out_tdata[18:17], out_tlast);
      words_seen++;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, expected none actual %h", $realtime, got);
        errors++;
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected %h actual %h", $realtime, want, got);
          errors++;
        end
      end
    end
  end

  task automatic drain();
    while (pending_items.size() > 0 || in_tvalid || expected_words.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_adapter(logic [1:0] a);
    @(negedge clk);
    cfg_data <= a;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    m_adapter = a;
    @(negedge clk);
    cfg_valid <= 1'b0;
    g_adapter = a;
    g_sel = m_crtc_sel;
  endtask

  task automatic random_phase(int count, logic [1:0] adapter);
    logic [15:0] base;
    int r;
    set_adapter(adapter);
    base = (adapter == ADAPTER_MDA) ? MONO_BASE : COLOR_BASE;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 5) gen_port(16'($urandom), 8'($urandom));
      else if (r < 10) gen_port(base + 16'($urandom_range(0, 9)), 8'($urandom));
      else if (r < 14) gen_crtc(CRTC_COLS, ($urandom_range(0, 9) == 0) ? 8'($urandom) :
                                 ($urandom_range(0, 1) ? 8'd40 : 8'd80));
      else if (r < 18) gen_crtc($urandom_range(0, 1) ? CRTC_START_HI : CRTC_START_LO,
                                8'($urandom));
      else if (r < 22) gen_port(base + 16'd8, 8'($urandom) | 8'h08);
      else if (r < 25) gen_port(base + 16'd9, 8'($urandom));
      else if (r < 32) gen_mem(14'($urandom), 8'($urandom));
      else if (r < 66) gen_text(($urandom_range(0, 9) == 0) ? 11'($urandom) :
                                11'($urandom_range(0, 999)));
      else gen_graph(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 199)),
                     ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 79)));
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < 16384; i++) begin vram[i] = '0; vram_ok[i] = 1'b0; end
    m_crtc_sel = '0; m_cols = 8'd80; m_start = '0; m_mode = '0; m_csel = '0;
    m_adapter = 2'd1;
    g_sel = '0; g_cols = 8'd80; g_start = '0; g_mode = '0; g_adapter = 2'd1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: disabled display, bad geometry, wrong kind, range edges, palettes.
    gen_text(11'd0);
    gen_graph(8'd0, 7'd0);
    gen_text(11'd2047);
    gen_port(COLOR_BASE + 16'd8, 8'h29);
    gen_text(11'd1999);
    gen_text(11'd2000);
    gen_crtc(CRTC_START_HI, 8'hff);
    gen_crtc(CRTC_START_LO, 8'hff);
    gen_text(11'd5);
    gen_crtc(CRTC_COLS, 8'd40);
    gen_port(COLOR_BASE + 16'd8, 8'h0a);
    gen_port(COLOR_BASE + 16'd9, 8'h3f);
    gen_graph(8'd199, 7'd79);
    gen_graph(8'd200, 7'd0);
    gen_graph(8'd0, 7'd127);
    gen_port(COLOR_BASE + 16'd8, 8'h0e);
    gen_graph(8'd1, 7'd3);
    gen_port(COLOR_BASE + 16'd8, 8'h1a);
    gen_graph(8'd2, 7'd4);
    gen_port(COLOR_BASE + 16'd8, 8'h12);
    gen_graph(8'd3, 7'd5);
    gen_text(11'd0);
    gen_crtc(CRTC_COLS, 8'd255);
    gen_graph(8'd0, 7'd0);
    drain();

    quiet_in = 1'b1; quiet_out = 1'b1;
    random_phase(20, 2'd1);
    quiet_in = 1'b0; quiet_out = 1'b0;
    random_phase(35, 2'd0);
    random_phase(25, 2'd2);
    random_phase(25, 2'd3);
    random_phase(25, 2'd1);

    $display("Sent %0d items across all adapter types and checked %0d result words.",
             items_sent, words_seen);
    if (errors == 0) begin
      $display("mda_cga_display_decoder_core test passed");
    end else begin
      $display("mda_cga_display_decoder_core test failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("mda_cga_display_decoder_core test failed");
    $finish;
  end
endmodule
